// ----- src/assert_macros.svh -----
// Assertion helpers for the refine selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cons follows ante in the same cycle, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/rcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the refine candidate selector.
// ----------------------------------------------------------------------------
package rcs_pkg;
  localparam int unsigned MaxItems       = 4096;
  localparam int unsigned MaxSelectDepth = 32;
  localparam int unsigned PrioW          = 25;
  localparam int unsigned IdxW           = 12;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 17;

  localparam logic [CfgIdxW-1:0] CfgStableMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgResThresh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgConfThresh = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxUnstable = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxSelect = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StScan,
    StShift,
    StClass,
    StEmit
  } state_e;
endpackage

// ----- src/rcs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_in_if / rcs_out_if
// Valid/ready channels of the refine candidate selector.
// ----------------------------------------------------------------------------
interface rcs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] obs_age;
  logic [15:0] color_residual;
  logic [15:0] depth_residual;
  logic [15:0] confidence;
  logic [23:0] frozen_until;
  logic [23:0] current_frame;
  logic        newly_active;
  logic        last_item;
  modport source (output valid, obs_age, color_residual, depth_residual, confidence,
                  frozen_until, current_frame, newly_active, last_item, input ready);
  modport sink (input valid, obs_age, color_residual, depth_residual, confidence,
                frozen_until, current_frame, newly_active, last_item, output ready);
endinterface

interface rcs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [11:0] item_index;
  logic        unstable;
  logic [24:0] priority_res;
  logic        end_of_run;
  modport source (output valid, result_kind, item_index, unstable, priority_res,
                  end_of_run, input ready);
  modport sink (input valid, result_kind, item_index, unstable, priority_res,
                end_of_run, output ready);
endinterface

// ----- src/rcs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_ram
// Generic simple dual-port RAM (one write port, one read port), registered read.
// ----------------------------------------------------------------------------
module rcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/rcs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcs_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [rcs_pkg::PrioW-1:0] dividend_i,
  input  logic [15:0]             divisor_i,
  output logic                    done_o,
  output logic [rcs_pkg::PrioW-1:0] quot_o
);
  localparam int unsigned W = rcs_pkg::PrioW;
  logic [$clog2(W+1)-1:0] cnt_q, cnt_d;
  logic [W-1:0]  q_q, q_d;
  logic [16:0]   r_q, r_d;
  logic [15:0]   dv_q, dv_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [16:0]   trial;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {r_q[15:0], q_q[W-1]};
    if (start_i) begin
      q_d = dividend_i; r_d = '0; dv_d = divisor_i;
      cnt_d = ($clog2(W+1))'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        r_d = trial - {1'b0, dv_q};
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

// ----- src/refine_candidate_top_k_selector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refine_candidate_top_k_selector_unit
// Classifies map elements, computes refine priority, keeps a sorted top list
// and emits the chosen indices at the end of each pass.
// ----------------------------------------------------------------------------
// channel   | dir | word
// in_w      | in  | element metadata, one per element
// out_w     | out | classification, then selected indices on the last element
// cfg       | in  | write enable, index, data (5 registers)
//
// An unstable element is accepted and divided for its 25-bit priority. Then a
// list scan finds the insert position, each entry behind it is read and written
// one place back, and the new entry is written, unless the list is full and it
// ranks last. The classification word follows. A stable element goes straight
// to its classification word. Selected words come out one at a time, each read
// from the RAMs. rst_ni clears counters, fill and control, not the RAMs. out_w
// stalls simply hold the sequencer in its class or emit state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module refine_candidate_top_k_selector_unit #(
  parameter int unsigned MaxItems       = rcs_pkg::MaxItems,
  parameter int unsigned MaxSelectDepth = rcs_pkg::MaxSelectDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rcs_in_if.sink                       in_w,
  rcs_out_if.source                    out_w,
  input  logic                         cfg_we_i,
  input  logic [rcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcs_pkg::CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned AW = (MaxSelectDepth > 1) ? $clog2(MaxSelectDepth) : 1;
  localparam int unsigned FW = $clog2(MaxSelectDepth + 1);
  localparam int unsigned CW = $clog2(MaxItems);
  localparam int unsigned PW = rcs_pkg::PrioW;
  localparam int unsigned IW = rcs_pkg::IdxW;

  // configuration
  logic [15:0] stable_min_q, conf_thr_q;
  logic [16:0] res_thr_q;
  logic [12:0] max_unst_q;
  logic [5:0]  max_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_min_q <= 16'd3; res_thr_q <= 17'h1FFFF; conf_thr_q <= '0;
      max_unst_q <= 13'd4096; max_sel_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcs_pkg::CfgStableMin:   stable_min_q <= cfg_data_i[15:0];
        rcs_pkg::CfgResThresh:   res_thr_q    <= cfg_data_i;
        rcs_pkg::CfgConfThresh:  conf_thr_q   <= cfg_data_i[15:0];
        rcs_pkg::CfgMaxUnstable: max_unst_q   <= cfg_data_i[12:0];
        rcs_pkg::CfgMaxSelect:   max_sel_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  rcs_pkg::state_e state_q, state_d;
  logic [CW-1:0] elem_cnt_q, elem_cnt_d;
  logic [12:0]   unst_cnt_q, unst_cnt_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] ptr_q, ptr_d;      // scan / shift / emit pointer
  logic [FW-1:0] pos_q, pos_d;      // insert position
  logic [FW-1:0] sel_q, sel_d;
  logic          unst_q, unst_d, last_q, last_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [PW-1:0] prio_q, prio_d;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [IW-1:0] widx, ridx;
  logic [PW-1:0] wprio, rprio;
  logic          rd_ok_q, rd_ok_d;  // read data valid for the previous read addr

  rcs_ram #(.Width(IW), .Depth(MaxSelectDepth)) u_idx_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(widx), .raddr_i(raddr), .rdata_o(ridx));
  rcs_ram #(.Width(PW), .Depth(MaxSelectDepth)) u_prio_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wprio), .raddr_i(raddr), .rdata_o(rprio));

  // divider loads straight from the accepted word: (256 + cres) * 256 / max(1, age)
  logic          div_start, div_done;
  logic [PW-1:0] quot;
  logic [15:0]   den;
  assign den = (in_w.obs_age == 16'd0) ? 16'd1 : in_w.obs_age;

  rcs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({1'b0, in_w.color_residual, 8'd0} + 25'd65536),
    .divisor_i(den), .done_o(div_done), .quot_o(quot));

  // classification
  logic cand;
  assign cand = (in_w.obs_age < stable_min_q)
      || ({1'b0, in_w.color_residual} + {1'b0, in_w.depth_residual} > res_thr_q)
      || (in_w.confidence < conf_thr_q) || (in_w.frozen_until > in_w.current_frame)
      || in_w.newly_active;

  logic acc, o_fire;
  assign acc = in_w.valid && in_w.ready;
  assign o_fire = out_w.valid && out_w.ready;

  logic [FW-1:0] sel_lim;
  logic [6:0] ms_clip;
  assign ms_clip = (max_sel_q > 6'(MaxSelectDepth)) ? 7'(MaxSelectDepth) : {1'b0, max_sel_q};

  always_comb begin
    state_d = state_q; elem_cnt_d = elem_cnt_q; unst_cnt_d = unst_cnt_q;
    fill_d = fill_q; ptr_d = ptr_q; pos_d = pos_q; sel_d = sel_q;
    unst_d = unst_q; last_d = last_q; idx_d = idx_q; prio_d = prio_q;
    rd_ok_d = 1'b0; div_start = 1'b0;
    we = 1'b0; waddr = '0; widx = '0; wprio = '0; raddr = '0;
    sel_lim = (7'(fill_q) < ms_clip) ? fill_q : FW'(ms_clip);
    in_w.ready = (state_q == rcs_pkg::StIdle);
    out_w.valid = 1'b0; out_w.result_kind = 1'b0; out_w.item_index = '0;
    out_w.unstable = 1'b0; out_w.priority_res = '0; out_w.end_of_run = 1'b0;
    case (state_q)
      rcs_pkg::StIdle: begin
        if (acc) begin
          idx_d = elem_cnt_q; last_d = in_w.last_item; prio_d = '0;
          if (elem_cnt_q != CW'(MaxItems - 1)) elem_cnt_d = elem_cnt_q + 1'b1;
          unst_d = cand && (unst_cnt_q < max_unst_q);
          if (cand && (unst_cnt_q < max_unst_q)) begin
            unst_cnt_d = unst_cnt_q + 1'b1;
            div_start = 1'b1;
            state_d = rcs_pkg::StDiv;
          end else begin
            state_d = rcs_pkg::StClass;
          end
        end
      end
      rcs_pkg::StDiv: begin
        if (div_done) begin
          prio_d = quot; ptr_d = '0; state_d = rcs_pkg::StScan;
        end
      end
      rcs_pkg::StScan: begin
        // issue read at ptr; compare read data of ptr-1 when valid
        raddr = AW'(ptr_q);
        if (rd_ok_q && rprio < prio_q) begin
          pos_d = ptr_q - 1'b1;
          ptr_d = (fill_q == FW'(MaxSelectDepth)) ? FW'(MaxSelectDepth - 1) : fill_q;
          state_d = rcs_pkg::StShift;
        end else if (ptr_q == fill_q) begin
          pos_d = fill_q; ptr_d = fill_q;
          state_d = (fill_q == FW'(MaxSelectDepth)) ? rcs_pkg::StClass : rcs_pkg::StShift;
        end else begin
          ptr_d = ptr_q + 1'b1; rd_ok_d = 1'b1;
        end
      end
      rcs_pkg::StShift: begin
        // ptr_q > pos: read ptr-1, then write into ptr next cycle
        if (ptr_q == pos_q) begin
          we = 1'b1; waddr = AW'(pos_q); widx = IW'(idx_q); wprio = prio_q;
          if (fill_q != FW'(MaxSelectDepth)) fill_d = fill_q + 1'b1;
          state_d = rcs_pkg::StClass;
        end else begin
          raddr = AW'(ptr_q - 1'b1);
          if (rd_ok_q) begin
            we = 1'b1; waddr = AW'(ptr_q); widx = ridx; wprio = rprio;
            ptr_d = ptr_q - 1'b1;
          end else begin
            rd_ok_d = 1'b1;
          end
        end
      end
      rcs_pkg::StClass: begin
        out_w.valid = 1'b1; out_w.item_index = IW'(idx_q);
        out_w.unstable = unst_q; out_w.priority_res = prio_q;
        out_w.end_of_run = !last_q || (sel_lim == 0);
        raddr = '0;
        if (o_fire) begin
          sel_d = sel_lim; ptr_d = '0;
          if (!last_q) state_d = rcs_pkg::StIdle;
          else if (sel_lim == 0) begin
            state_d = rcs_pkg::StIdle; elem_cnt_d = '0; unst_cnt_d = '0; fill_d = '0;
          end else state_d = rcs_pkg::StEmit;
        end
      end
      rcs_pkg::StEmit: begin
        // RAM output holds entry ptr_q (address held until advance)
        raddr = AW'(ptr_q);
        out_w.valid = rd_ok_q; out_w.result_kind = 1'b1; out_w.item_index = ridx;
        out_w.unstable = 1'b1; out_w.priority_res = rprio;
        out_w.end_of_run = (ptr_q + 1'b1 == sel_q);
        rd_ok_d = 1'b1;
        if (o_fire) begin
          rd_ok_d = 1'b0;
          ptr_d = ptr_q + 1'b1;
          if (ptr_q + 1'b1 == sel_q) begin
            state_d = rcs_pkg::StIdle; elem_cnt_d = '0; unst_cnt_d = '0; fill_d = '0;
          end
        end
      end
      default: state_d = rcs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcs_pkg::StIdle; elem_cnt_q <= '0; unst_cnt_q <= '0; fill_q <= '0;
      ptr_q <= '0; rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d; elem_cnt_q <= elem_cnt_d; unst_cnt_q <= unst_cnt_d;
      fill_q <= fill_d; ptr_q <= ptr_d; rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; sel_q <= sel_d; unst_q <= unst_d; last_q <= last_d;
    idx_q <= idx_d; prio_q <= prio_d;
  end

  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= FW'(MaxSelectDepth),
    "top list fill beyond depth")
  `ASSERT_IMPLIES(a_no_accept_busy, clk_i, rst_ni, state_q != rcs_pkg::StIdle,
    !in_w.ready, "input ready while busy")
  `ASSERT_IMPLIES(a_stable_zero, clk_i, rst_ni,
    out_w.valid && !out_w.result_kind && !out_w.unstable, out_w.priority_res == '0,
    "stable element with nonzero priority")
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the refine candidate selector: element words are
// driven with random gaps, the selector's results are predicted in-bench and
// compared word by word, over several register settings.
// ----------------------------------------------------------------------------
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rcs_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rcs_pkg::CfgDataW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  rcs_in_if in_w ();
  rcs_out_if out_w ();

  refine_candidate_top_k_selector_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_w.sink), .out_w(out_w.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  typedef struct packed {
    logic [15:0] age;
    logic [15:0] cres;
    logic [15:0] dres;
    logic [15:0] conf;
    logic [23:0] frozen;
    logic [23:0] frame;
    logic        active;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] idx;
    logic        unst;
    logic [24:0] prio;
    logic        eor;
  } res_t;

  // predictor state: register copies and pass state
  logic [15:0] p_stable_min = 16'd3;
  logic [16:0] p_res_thresh = 17'h1ffff;
  logic [15:0] p_conf_thresh = 16'd0;
  logic [12:0] p_max_unstable = 13'd4096;
  logic [5:0]  p_max_select = 6'd32;
  int unsigned elem_count, unst_count, list_fill;
  logic [11:0] list_idx [rcs_pkg::MaxSelectDepth];
  logic [24:0] list_prio [rcs_pkg::MaxSelectDepth];

  elem_t pending_elems [$];
  res_t  expected_results [$];
  int    errors = 0;
  logic [23:0] pass_frame;

  function automatic void queue_elem(elem_t e);
    pending_elems.insert(pending_elems.size(), e);
  endfunction

  // sorted insert, ties behind equal-or-higher entries
  function automatic void list_insert(logic [11:0] idx, logic [24:0] prio);
    int unsigned pos, j;
    pos = 0;
    while (pos < list_fill && list_prio[pos] >= prio) pos++;
    if (pos >= rcs_pkg::MaxSelectDepth) return;
    j = (list_fill < rcs_pkg::MaxSelectDepth) ? list_fill : rcs_pkg::MaxSelectDepth - 1;
    while (j > pos) begin
      list_idx[j] = list_idx[j-1];
      list_prio[j] = list_prio[j-1];
      j--;
    end
    list_idx[pos] = idx;
    list_prio[pos] = prio;
    if (list_fill < rcs_pkg::MaxSelectDepth) list_fill++;
  endfunction

  function automatic void predict_selection(elem_t e);
    bit unst;
    logic [24:0] prio;
    logic [11:0] idx;
    int unsigned sel, den;
    res_t r;
    idx = elem_count[11:0];
    prio = '0;
    unst = e.age < p_stable_min || (17'(e.cres) + 17'(e.dres)) > p_res_thresh ||
           e.conf < p_conf_thresh || e.frozen > e.frame || e.active;
    if (unst && unst_count >= p_max_unstable) unst = 0;
    if (unst) begin
      den = (e.age > 0) ? e.age : 1;
      unst_count++;
      prio = 25'(((256 + int'(e.cres)) * 256) / den);
      list_insert(idx, prio);
    end
    if (elem_count < rcs_pkg::MaxItems - 1) elem_count++;
    sel = p_max_select;
    if (sel > rcs_pkg::MaxSelectDepth) sel = rcs_pkg::MaxSelectDepth;
    if (sel > list_fill) sel = list_fill;
    r = '{kind: 1'b0, idx: idx, unst: unst, prio: prio,
          eor: (!e.last || sel == 0)};
    expected_results.insert(expected_results.size(), r);
    if (e.last) begin
      for (int k = 0; k < sel; k++) begin
        r = '{kind: 1'b1, idx: list_idx[k], unst: 1'b1, prio: list_prio[k],
              eor: (k + 1 == sel)};
        expected_results.insert(expected_results.size(), r);
      end
      elem_count = 0;
      unst_count = 0;
      list_fill = 0;
    end
  endfunction

  // ---- driver: one word at a time, random gap before each ----
  int unsigned send_gap = 0;
  elem_t cur_elem;
  bit in_acc_seen = 1'b0;
  initial begin
    in_w.valid = 1'b0;
    {in_w.obs_age, in_w.color_residual, in_w.depth_residual, in_w.confidence,
     in_w.frozen_until, in_w.current_frame, in_w.newly_active, in_w.last_item} = '0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc_seen) begin
        // accepted at the last rising edge
        in_w.valid <= 1'b0;
        send_gap <= $urandom_range(0, 15);
      end else if (!in_w.valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_elems.size() > 0) begin
          cur_elem = pending_elems.pop_front();
          in_w.obs_age <= cur_elem.age;
          in_w.color_residual <= cur_elem.cres;
          in_w.depth_residual <= cur_elem.dres;
          in_w.confidence <= cur_elem.conf;
          in_w.frozen_until <= cur_elem.frozen;
          in_w.current_frame <= cur_elem.frame;
          in_w.newly_active <= cur_elem.active;
          in_w.last_item <= cur_elem.last;
          in_w.valid <= 1'b1;
        end
      end
    end
  end

  // predict on acceptance, at the rising edge
  always @(posedge clk_i) begin
    in_acc_seen <= rst_ni && in_w.valid && in_w.ready;
    if (rst_ni && in_w.valid && in_w.ready)
      predict_selection('{age: in_w.obs_age, cres: in_w.color_residual,
        dres: in_w.depth_residual, conf: in_w.confidence, frozen: in_w.frozen_until,
        frame: in_w.current_frame, active: in_w.newly_active, last: in_w.last_item});
  end

  // ---- monitor: random back-pressure, compare each result word ----
  int unsigned stall_left = 0;
  int unsigned out_draw;
  bit out_acc_seen = 1'b0;
  initial out_w.ready = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc_seen) begin
        out_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (out_draw == 0) begin
          out_w.ready <= 1'b1;
        end else begin
          out_w.ready <= 1'b0;
          stall_left <= out_draw - 1;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    out_acc_seen <= rst_ni && out_w.valid && out_w.ready;
    if (rst_ni && out_w.valid && out_w.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word, index %0d", out_w.item_index);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_w.result_kind !== want.kind) begin
          $error("result_kind exp %0d got %0d", want.kind, out_w.result_kind); errors++;
        end
        if (out_w.item_index !== want.idx) begin
          $error("item_index exp %0d got %0d", want.idx, out_w.item_index); errors++;
        end
        if (out_w.unstable !== want.unst) begin
          $error("unstable exp %0d got %0d", want.unst, out_w.unstable); errors++;
        end
        if (out_w.priority_res !== want.prio) begin
          $error("priority_res exp %0d got %0d", want.prio, out_w.priority_res); errors++;
        end
        if (out_w.end_of_run !== want.eor) begin
          $error("end_of_run exp %0d got %0d", want.eor, out_w.end_of_run); errors++;
        end
      end
    end
  end

  // ---- watchdog: cycles without any accepted word ----
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- stimulus ----
  function automatic elem_t rand_elem(bit last);
    elem_t e;
    e.age = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
    e.cres = 16'($urandom);
    e.dres = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 255));
    e.conf = 16'($urandom);
    e.frozen = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 100));
    e.frame = pass_frame;
    e.active = ($urandom_range(0, 4) == 0);
    e.last = last;
    return e;
  endfunction

  function automatic elem_t fixed_elem(logic [15:0] age, logic [15:0] cres,
      logic [15:0] dres, logic [15:0] conf, logic [23:0] frozen, logic act, logic last);
    return '{age: age, cres: cres, dres: dres, conf: conf, frozen: frozen,
             frame: pass_frame, active: act, last: last};
  endfunction

  task automatic cfg_write(logic [rcs_pkg::CfgIdxW-1:0] idx,
      logic [rcs_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      rcs_pkg::CfgStableMin:   p_stable_min = val[15:0];
      rcs_pkg::CfgResThresh:   p_res_thresh = val;
      rcs_pkg::CfgConfThresh:  p_conf_thresh = val[15:0];
      rcs_pkg::CfgMaxUnstable: p_max_unstable = val[12:0];
      rcs_pkg::CfgMaxSelect:   p_max_select = val[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every queued word is sent and answered, then let the clock run on
  task automatic drain();
    wait (pending_elems.size() == 0 && !in_w.valid && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_pass(int unsigned n);
    pass_frame = 24'($urandom);
    for (int i = 0; i < n; i++) queue_elem(rand_elem(i == n - 1));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed pass at reset settings: field extremes, ties, the age and newly-active triggers
    pass_frame = 24'hffffff;
    queue_elem(fixed_elem(16'd0, 16'hffff, 16'hffff, 16'hffff, 24'd0, 0, 0));
    queue_elem(fixed_elem(16'hffff, 16'd0, 16'd0, 16'd0, 24'hffffff, 1, 0));
    queue_elem(fixed_elem(16'd1, 16'd0, 16'd0, 16'hffff, 24'd0, 0, 0));
    queue_elem(fixed_elem(16'd1, 16'd0, 16'd0, 16'hffff, 24'd0, 0, 0)); // tie
    queue_elem(fixed_elem(16'd3, 16'd0, 16'd0, 16'hffff, 24'd0, 0, 0)); // stable
    queue_elem(fixed_elem(16'd2, 16'h8000, 16'h5555, 16'haaaa, 24'h0, 0, 1));
    drain();

    // thresholds at the other extremes: residual sum, confidence, frozen
    cfg_write(rcs_pkg::CfgStableMin, 17'd0);
    cfg_write(rcs_pkg::CfgResThresh, 17'd0);
    cfg_write(rcs_pkg::CfgConfThresh, 17'hffff);
    cfg_write(rcs_pkg::CfgMaxSelect, 17'd0);
    pass_frame = 24'd0;
    queue_elem(fixed_elem(16'd5, 16'd0, 16'd0, 16'hffff, 24'd0, 0, 0));
    queue_elem(fixed_elem(16'd5, 16'd0, 16'd1, 16'hffff, 24'd0, 0, 0));
    queue_elem(fixed_elem(16'd5, 16'd7, 16'd0, 16'hfffe, 24'd0, 0, 0));
    queue_elem(fixed_elem(16'd5, 16'd0, 16'd0, 16'hffff, 24'd1, 0, 1));
    drain();

    // cap of zero, then a two-element pass
    cfg_write(rcs_pkg::CfgMaxUnstable, 17'd0);
    cfg_write(rcs_pkg::CfgMaxSelect, 17'd63);
    queue_elem(fixed_elem(16'd0, 16'd9, 16'd9, 16'd0, 24'd9, 1, 0));
    queue_elem(fixed_elem(16'd0, 16'd9, 16'd9, 16'd0, 24'd9, 1, 1));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(rcs_pkg::CfgStableMin, 17'($urandom_range(0, 6)));
      cfg_write(rcs_pkg::CfgResThresh, (ph == 0) ? 17'h1ffff : 17'($urandom));
      cfg_write(rcs_pkg::CfgConfThresh, 17'($urandom_range(0, 65535)));
      cfg_write(rcs_pkg::CfgMaxUnstable,
                (ph == 1) ? 17'd4096 : 17'($urandom_range(0, 40)));
      cfg_write(rcs_pkg::CfgMaxSelect, (ph == 2) ? 17'd32 : 17'($urandom_range(0, 40)));
      for (int p = 0; p < 2; p++) random_pass($urandom_range(1, 20));
      if (ph == 3) drain(); // sender waits out every result once
      random_pass(24);
      drain();
    end
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
